FILE: sv/assert_macros.svh
// Assertion macros used by the integer execute unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: sv/m68k_pkg.sv
// Shared types and codes for the 68000 integer execute unit.
`default_nettype none
package m68k_pkg;
  localparam int unsigned DivCells = 16;
  localparam logic [3:0] FN_DIVS = 4'd0;
  localparam logic [3:0] FN_DIVU = 4'd1;
  localparam logic [3:0] FN_MULS = 4'd2;
  localparam logic [3:0] FN_MULU = 4'd3;
  localparam logic [3:0] FN_NEG  = 4'd4;
  localparam logic [3:0] FN_NEGX = 4'd5;
  localparam logic [3:0] FN_CMP  = 4'd6;
  localparam logic [3:0] FN_CMPA = 4'd7;
  localparam logic [3:0] FN_TST  = 4'd8;
  localparam logic [3:0] FN_CLR  = 4'd9;
  localparam logic [3:0] FN_EXT  = 4'd10;
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  typedef struct packed {
    logic [31:0] value;
    logic        wb;
    logic [4:0]  ccr;
    logic        status;
  } res_t;

  // item moving down the divider chain
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        is_signed;
    logic        neg_q;
    logic        neg_r;
    logic        ovf;
    logic [31:0] rem;   // running remainder / shifting dividend
    logic [15:0] quo;
    logic [15:0] dvs;   // divisor magnitude
    logic [31:0] dmag;  // dividend magnitude (kept for overflow check)
    res_t        res;   // non-divide result or divide template
  } div_t;
endpackage
`default_nettype wire

FILE: sv/m68k_integer_arith_unit.sv
// Top level of the 68000 integer execute unit.
// Accepts one request per cycle while the output is not stalled. Every request passes
// a front stage, a chain of 16 division cells (one quotient bit each) and an output
// stage. Stalling the output holds the whole chain.
`default_nettype none
module m68k_integer_arith_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // func[3:0], size[5:4], source_operand[37:6], dest_operand[69:38], ccr_in[74:70]
  input  wire logic [79:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_value[31:0], write_back[32], ccr_out[37:33], status[38]
  output      logic [39:0] m_axis_tdata
);
  import m68k_pkg::*;
  logic [3:0] fn; logic [1:0] sz; logic [31:0] s, d; logic [4:0] cc;
  assign fn = s_axis_tdata[3:0];
  assign sz = s_axis_tdata[5:4];
  assign s  = s_axis_tdata[37:6];
  assign d  = s_axis_tdata[69:38];
  assign cc = s_axis_tdata[74:70];

  logic en;
  div_t chain [0:DivCells];
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [31:0] m, sb, dm_v, r, a, b, mul;
  logic [4:0] ncc;
  logic dmb, rmb, smb, xin, c;
  res_t res;
  logic [15:0] dv, dvmag;
  logic [31:0] dmag;
  always_comb begin
    m = (sz == SZ_BYTE) ? 32'hff : (sz == SZ_WORD) ? 32'hffff : 32'hffffffff;
    sb = (m >> 1) + 32'd1;
    res.value = d; res.wb = 1'b0; res.ccr = cc; res.status = 1'b0;
    r = '0; a = '0; b = '0; dmb = 1'b0; rmb = 1'b0; smb = 1'b0; xin = 1'b0;
    c = 1'b0; ncc = '0; dm_v = '0; mul = '0;
    dv = s[15:0];
    dvmag = (fn == FN_DIVS && dv[15]) ? 16'(-dv) : dv;
    dmag = (fn == FN_DIVS && d[31]) ? 32'(-d) : d;
    case (fn)
      FN_DIVS, FN_DIVU: begin
        if (dv == 16'd0) begin
          res.status = 1'b1; res.ccr = {cc[4:1], 1'b0};
        end
      end
      FN_MULS: begin
        mul = 32'($signed(s[15:0]) * $signed(d[15:0]));
        res.value = mul; res.wb = 1'b1;
        res.ccr = {cc[4], mul[31], mul == 32'd0, 2'b00};
      end
      FN_MULU: begin
        mul = s[15:0] * d[15:0];
        res.value = mul; res.wb = 1'b1;
        res.ccr = {cc[4], mul[31], mul == 32'd0, 2'b00};
      end
      FN_NEG, FN_NEGX: begin
        xin = (fn == FN_NEGX) && cc[4];
        r = (32'd0 - (d & m) - {31'd0, xin}) & m;
        dmb = |(d & sb); rmb = |(r & sb);
        ncc[3] = rmb;
        if (fn == FN_NEG) begin
          ncc[2] = (r == 32'd0); c = (r != 32'd0);
        end else begin
          ncc[2] = (r == 32'd0) && cc[2]; c = dmb | rmb;
        end
        ncc[1] = dmb & rmb;
        ncc[0] = c; ncc[4] = c;
        res.value = (d & ~m) | r; res.wb = 1'b1; res.ccr = ncc;
      end
      FN_CMP, FN_CMPA: begin
        if (fn == FN_CMPA) begin
          m = 32'hffffffff; sb = 32'h80000000;
          a = sz[1] ? s : {{16{s[15]}}, s[15:0]};
        end else a = s & m;
        b = d & m;
        r = (b - a) & m;
        smb = |(a & sb); dmb = |(b & sb); rmb = |(r & sb);
        res.ccr = {cc[4], rmb, r == 32'd0,
                   (!smb && dmb && !rmb) || (smb && !dmb && rmb),
                   (smb && !dmb) || (rmb && !dmb) || (smb && rmb)};
      end
      FN_TST: res.ccr = {cc[4], |(d & sb), (d & m) == 32'd0, 2'b00};
      FN_CLR: begin
        res.value = d & ~m; res.wb = 1'b1; res.ccr = {cc[4], 4'b0100};
      end
      FN_EXT: begin
        if (sz[1]) begin
          dm_v = {{16{d[15]}}, d[15:0]};
          res.value = dm_v; res.ccr = {cc[4], dm_v[31], dm_v == 32'd0, 2'b00};
        end else begin
          dm_v = {d[31:16], {8{d[7]}}, d[7:0]};
          res.ccr = {cc[4], dm_v[15], dm_v[15:0] == 16'd0, 2'b00};
          res.value = dm_v;
        end
        res.wb = 1'b1;
      end
      default: ;
    endcase
  end

  div_t f_d, f_q;
  always_comb begin
    f_d.valid = s_axis_tvalid;
    f_d.is_div = (fn == FN_DIVS || fn == FN_DIVU) && dv != 16'd0;
    f_d.is_signed = fn == FN_DIVS;
    f_d.neg_q = (fn == FN_DIVS) && (d[31] ^ dv[15]);
    f_d.neg_r = (fn == FN_DIVS) && d[31];
    f_d.ovf = 1'b0;
    f_d.rem = dmag; f_d.quo = '0; f_d.dvs = dvmag; f_d.dmag = dmag;
    f_d.res = res;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_q <= '0;
    else if (en) f_q <= f_d;
  end
  // overflow: unsigned quotient >= 2^16 iff dividend[31:16] >= divisor
  div_t c0;
  always_comb begin
    c0 = f_q;
    c0.ovf = f_q.is_div && (f_q.dmag[31:16] >= f_q.dvs);
  end
  // cells shift the dividend low half in from rem's own low bits: rem[31:16] holds the high part
  div_t c0b;
  always_comb begin
    c0b = c0;
    c0b.rem = {c0.dmag[31:16] & {16{~c0.ovf}}, c0.dmag[15:0]};
  end
  assign chain[0] = c0b;
  genvar gi;
  generate
    for (gi = 0; gi < DivCells; gi++) begin : g_cell
      m68k_cell u_cell (.clk_i, .rst_ni, .en_i(en), .in_i(chain[gi]),
                        .out_o(chain[gi+1]));
    end
  endgenerate

  div_t l;
  logic [15:0] q, rm16;
  logic big;
  res_t o_d, o_q;
  logic v_q;
  assign l = chain[DivCells];
  always_comb begin
    q = l.neg_q ? 16'(-l.quo) : l.quo;
    rm16 = l.neg_r ? 16'(-l.rem[31:16]) : l.rem[31:16];
    big = l.neg_q ? (l.quo > 16'h8000) : l.quo[15];
    o_d = l.res;
    if (l.is_div) begin
      if (l.ovf || (l.is_signed && big)) begin
        o_d.ccr = {l.res.ccr[4:2], 2'b10};
      end else begin
        o_d.value = {rm16, q}; o_d.wb = 1'b1;
        o_d.ccr = {l.res.ccr[4], q[15], q == 16'd0, 2'b00};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= l.valid;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_q <= '0;
    else if (en) o_q <= o_d;
  end
  assign m_axis_tvalid = v_q;
  assign m_axis_tdata = {1'b0, o_q.status, o_q.ccr, o_q.wb, o_q.value};

`include "assert_macros.svh"
  `ASSERT_IMPL(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "hold")
  `ASSERT_NEVER(a_dz, m_axis_tvalid && o_q.status && o_q.wb, "div0 wrote")
  `ASSERT_NEVER(a_rdy, s_axis_tready != (!m_axis_tvalid || m_axis_tready), "ready")
endmodule
`default_nettype wire

FILE: sv/m68k_cell.sv
// One restoring-division cell: one quotient bit per cycle while en_i is high.
`default_nettype none
module m68k_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire m68k_pkg::div_t   in_i,
  output m68k_pkg::div_t        out_o
);
  import m68k_pkg::*;
  div_t d_d, d_q;
  logic [32:0] trial;
  always_comb begin
    d_d = in_i;
    trial = {in_i.rem, 1'b0} - {1'b0, in_i.dvs, 16'd0};
    if (in_i.is_div) begin
      if (!trial[32]) begin
        d_d.rem = trial[31:0];
        d_d.quo = {in_i.quo[14:0], 1'b1};
      end else begin
        d_d.rem = {in_i.rem[30:0], 1'b0};
        d_d.quo = {in_i.quo[14:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_q <= '0;
    else if (en_i) d_q <= d_d;
  end
  assign out_o = d_q;
endmodule
`default_nettype wire
